/* src/spiee_pkg.sv */
// Shared types and codes for the SPI EEPROM command sequencer.
// Depends on nothing; imported by spi_eeprom_command_sequencer.
`default_nettype none

package spiee_pkg;

    // EEPROM instruction set
    localparam logic [7:0] OP_WREN  = 8'h06;
    localparam logic [7:0] OP_WRDI  = 8'h04;
    localparam logic [7:0] OP_RDSR  = 8'h05;
    localparam logic [7:0] OP_READ  = 8'h03;
    localparam logic [7:0] OP_WRITE = 8'h02;
    localparam logic [7:0] OP_WRSR  = 8'h01;

    // Request codes on the input tuser
    typedef logic [2:0] req_t;
    localparam req_t REQ_WRITE     = 3'd0;
    localparam req_t REQ_READ      = 3'd1;
    localparam req_t REQ_WR_STATUS = 3'd2;
    localparam req_t REQ_RD_STATUS = 3'd3;
    localparam req_t REQ_SET_LATCH = 3'd4;
    localparam req_t REQ_CLR_LATCH = 3'd5;
    localparam req_t REQ_REPLY     = 3'd6;

    // Sequencer modes
    typedef logic [2:0] mode_t;
    localparam mode_t M_IDLE  = 3'd0;
    localparam mode_t M_POLL  = 3'd1;
    localparam mode_t M_WRUN  = 3'd2;
    localparam mode_t M_WGAP  = 3'd3;
    localparam mode_t M_RRUN  = 3'd4;
    localparam mode_t M_RNEXT = 3'd5;
    localparam mode_t M_STAT  = 3'd6;

    // Result kinds on the output tuser
    typedef logic [1:0] kind_t;
    localparam kind_t K_BUS  = 2'd0;
    localparam kind_t K_HOST = 2'd1;
    localparam kind_t K_ERR  = 2'd2;

    localparam int MAX_RESULTS = 5;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] mosi_byte;
        logic       frame_end;
        logic       capture;
        logic [7:0] host_byte;
        logic       last_result;
    } result_t;

    function automatic result_t mk_res(kind_t k, logic [7:0] m, logic fe, logic cap,
                                       logic [7:0] h);
        result_t r;
        r.kind        = k;
        r.mosi_byte   = m;
        r.frame_end   = fe;
        r.capture     = cap;
        r.host_byte   = h;
        r.last_result = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

/* src/spi_eeprom_command_sequencer.sv */
// Top level of the SPI EEPROM command sequencer: input register, sequencing logic
// and a five-entry result queue. Depends on spiee_pkg.
`default_nettype none

// Turns host requests and device reply bytes into SPI bus bytes (with chip-select
// framing and a capture flag) or host data. Write, read, write-status and
// clear-latch requests are preceded by RDSR polling until the busy bit clears;
// writes go out in chunks of CHUNK_BYTES, each re-polled and addressed on its own.
// Each input word is registered and decoded combinationally into one to five result
// words, and those are then shifted out one per cycle while m_tready is high. An
// input word thus takes as many output transfers as the results it causes (one to
// five); the result queue drain is what sets the rate. A new input word is taken
// while the previous one's last result is being delivered.
module spi_eeprom_command_sequencer
    import spiee_pkg::*;
#(
    parameter int CHUNK_BYTES = 32,
    parameter int ADDR_BITS   = 16
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [23:0] s_tdata,   // address[15:0], data[23:16]
    input  wire logic [2:0]  s_tuser,   // req_type[2:0]
    input  wire logic        s_tlast,
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [23:0] m_tdata,   // mosi_byte[7:0], frame_end[8], capture[9],
                                        // host_byte[17:10], zero pad[23:18]
    output      logic [1:0]  m_tuser,   // kind[1:0]
    output      logic        m_tlast    // last_result
);

    localparam int CW = $clog2(CHUNK_BYTES + 1);
    localparam int AW = ADDR_BITS;

    // input register
    logic           in_valid_reg;
    req_t           in_type_reg;
    logic [AW-1:0]  in_addr_reg;
    logic [7:0]     in_data_reg;
    logic           in_last_reg;

    // sequencer state
    mode_t          seq_mode_reg, seq_mode_next;
    req_t           pending_op_reg, pending_op_next;
    logic [7:0]     pending_byte_reg, pending_byte_next;
    logic           pending_last_reg, pending_last_next;
    logic [CW-1:0]  chunk_count_reg, chunk_count_next;
    logic [AW-1:0]  next_address_reg, next_address_next;

    // result queue
    result_t        out_buf_reg [MAX_RESULTS];
    logic [2:0]     out_cnt_reg;

    result_t        res [MAX_RESULTS];
    logic [2:0]     n_v;
    logic           err;
    logic [15:0]    addr16;
    logic [CW-1:0]  cnt_plus;
    logic [7:0]     wd_byte;
    logic           wd_last;
    logic           out_free;
    logic           move;
    logic           pop;

    assign pop      = m_tvalid && m_tready;
    assign out_free = (out_cnt_reg == 3'd0) || (out_cnt_reg == 3'd1 && m_tready);
    assign move     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || move;

    assign m_tvalid = (out_cnt_reg != 3'd0);
    assign m_tdata  = {6'b0, out_buf_reg[0].host_byte, out_buf_reg[0].capture,
                       out_buf_reg[0].frame_end, out_buf_reg[0].mosi_byte};
    assign m_tuser  = out_buf_reg[0].kind;
    assign m_tlast  = out_buf_reg[0].last_result;

    assign addr16   = 16'(next_address_reg);
    // chunk counter restarts at the first data byte of a chunk
    assign cnt_plus = ((seq_mode_reg == M_POLL) ? CW'(0) : chunk_count_reg) + CW'(1);
    assign wd_byte  = (seq_mode_reg == M_POLL) ? pending_byte_reg : in_data_reg;
    assign wd_last  = (seq_mode_reg == M_POLL) ? pending_last_reg : in_last_reg;

    always_comb
    begin
        seq_mode_next     = seq_mode_reg;
        pending_op_next   = pending_op_reg;
        pending_byte_next = pending_byte_reg;
        pending_last_next = pending_last_reg;
        chunk_count_next  = chunk_count_reg;
        next_address_next = next_address_reg;
        err               = 1'b0;
        n_v               = 3'd0;
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            res[i] = mk_res(K_ERR, 8'h00, 1'b0, 1'b0, 8'h00);
        end

        case (seq_mode_reg)
            M_IDLE:
            begin
                if (in_type_reg == REQ_WRITE || in_type_reg == REQ_READ ||
                    in_type_reg == REQ_WR_STATUS || in_type_reg == REQ_CLR_LATCH)
                begin
                    pending_op_next   = in_type_reg;
                    pending_byte_next = in_data_reg;
                    pending_last_next = in_last_reg;
                    if (in_type_reg == REQ_WRITE || in_type_reg == REQ_READ)
                    begin
                        next_address_next = in_addr_reg;
                    end
                    res[0]        = mk_res(K_BUS, OP_RDSR, 1'b0, 1'b0, 8'h00);
                    res[1]        = mk_res(K_BUS, 8'h00, 1'b1, 1'b1, 8'h00);
                    n_v           = 3'd2;
                    seq_mode_next = M_POLL;
                end
                else if (in_type_reg == REQ_RD_STATUS)
                begin
                    res[0]        = mk_res(K_BUS, OP_RDSR, 1'b0, 1'b0, 8'h00);
                    res[1]        = mk_res(K_BUS, 8'h00, 1'b1, 1'b1, 8'h00);
                    n_v           = 3'd2;
                    seq_mode_next = M_STAT;
                end
                else if (in_type_reg == REQ_SET_LATCH)
                begin
                    res[0] = mk_res(K_BUS, OP_WREN, 1'b1, 1'b0, 8'h00);
                    n_v    = 3'd1;
                end
                else
                begin
                    err = 1'b1;
                end
            end
            M_POLL:
            begin
                if (in_type_reg != REQ_REPLY)
                begin
                    err = 1'b1;
                end
                else if (in_data_reg[0])
                begin
                    // still busy: poll again
                    res[0] = mk_res(K_BUS, OP_RDSR, 1'b0, 1'b0, 8'h00);
                    res[1] = mk_res(K_BUS, 8'h00, 1'b1, 1'b1, 8'h00);
                    n_v    = 3'd2;
                end
                else
                begin
                    case (pending_op_reg)
                        REQ_WRITE:
                        begin
                            res[0] = mk_res(K_BUS, OP_WREN, 1'b1, 1'b0, 8'h00);
                            res[1] = mk_res(K_BUS, OP_WRITE, 1'b0, 1'b0, 8'h00);
                            res[2] = mk_res(K_BUS, addr16[15:8], 1'b0, 1'b0, 8'h00);
                            res[3] = mk_res(K_BUS, addr16[7:0], 1'b0, 1'b0, 8'h00);
                            res[4] = mk_res(K_BUS, wd_byte,
                                            wd_last || (cnt_plus >= CW'(CHUNK_BYTES)),
                                            1'b0, 8'h00);
                            n_v               = 3'd5;
                            chunk_count_next  = cnt_plus;
                            next_address_next = next_address_reg + AW'(1);
                            if (wd_last)
                                seq_mode_next = M_IDLE;
                            else if (cnt_plus >= CW'(CHUNK_BYTES))
                                seq_mode_next = M_WGAP;
                            else
                                seq_mode_next = M_WRUN;
                        end
                        REQ_READ:
                        begin
                            res[0] = mk_res(K_BUS, OP_READ, 1'b0, 1'b0, 8'h00);
                            res[1] = mk_res(K_BUS, addr16[15:8], 1'b0, 1'b0, 8'h00);
                            res[2] = mk_res(K_BUS, addr16[7:0], 1'b0, 1'b0, 8'h00);
                            res[3] = mk_res(K_BUS, 8'h00, pending_last_reg, 1'b1, 8'h00);
                            n_v           = 3'd4;
                            seq_mode_next = M_RRUN;
                        end
                        REQ_WR_STATUS:
                        begin
                            res[0] = mk_res(K_BUS, OP_WRSR, 1'b0, 1'b0, 8'h00);
                            res[1] = mk_res(K_BUS, pending_byte_reg, 1'b1, 1'b0, 8'h00);
                            n_v           = 3'd2;
                            seq_mode_next = M_IDLE;
                        end
                        default:
                        begin
                            res[0]        = mk_res(K_BUS, OP_WRDI, 1'b1, 1'b0, 8'h00);
                            n_v           = 3'd1;
                            seq_mode_next = M_IDLE;
                        end
                    endcase
                end
            end
            M_WRUN:
            begin
                if (in_type_reg == REQ_WRITE)
                begin
                    res[0] = mk_res(K_BUS, wd_byte,
                                    wd_last || (cnt_plus >= CW'(CHUNK_BYTES)), 1'b0, 8'h00);
                    n_v               = 3'd1;
                    chunk_count_next  = cnt_plus;
                    next_address_next = next_address_reg + AW'(1);
                    if (wd_last)
                        seq_mode_next = M_IDLE;
                    else if (cnt_plus >= CW'(CHUNK_BYTES))
                        seq_mode_next = M_WGAP;
                    else
                        seq_mode_next = M_WRUN;
                end
                else
                begin
                    err = 1'b1;
                end
            end
            M_WGAP:
            begin
                if (in_type_reg == REQ_WRITE)
                begin
                    pending_op_next   = REQ_WRITE;
                    pending_byte_next = in_data_reg;
                    pending_last_next = in_last_reg;
                    res[0]        = mk_res(K_BUS, OP_RDSR, 1'b0, 1'b0, 8'h00);
                    res[1]        = mk_res(K_BUS, 8'h00, 1'b1, 1'b1, 8'h00);
                    n_v           = 3'd2;
                    seq_mode_next = M_POLL;
                end
                else
                begin
                    err = 1'b1;
                end
            end
            M_RRUN:
            begin
                if (in_type_reg == REQ_REPLY)
                begin
                    res[0]        = mk_res(K_HOST, 8'h00, 1'b0, 1'b0, in_data_reg);
                    n_v           = 3'd1;
                    seq_mode_next = pending_last_reg ? M_IDLE : M_RNEXT;
                end
                else
                begin
                    err = 1'b1;
                end
            end
            M_RNEXT:
            begin
                if (in_type_reg == REQ_READ)
                begin
                    pending_last_next = in_last_reg;
                    res[0]        = mk_res(K_BUS, 8'h00, in_last_reg, 1'b1, 8'h00);
                    n_v           = 3'd1;
                    seq_mode_next = M_RRUN;
                end
                else
                begin
                    err = 1'b1;
                end
            end
            M_STAT:
            begin
                if (in_type_reg == REQ_REPLY)
                begin
                    res[0]        = mk_res(K_HOST, 8'h00, 1'b0, 1'b0, in_data_reg);
                    n_v           = 3'd1;
                    seq_mode_next = M_IDLE;
                end
                else
                begin
                    err = 1'b1;
                end
            end
            default:
            begin
                seq_mode_next = M_IDLE;
                err           = 1'b1;
            end
        endcase

        // an error is always the only result of its word
        if (err)
        begin
            res[0] = mk_res(K_ERR, 8'h00, 1'b0, 1'b0, 8'h00);
            n_v    = 3'd1;
        end
        res[n_v - 3'd1].last_result = 1'b1;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_cnt_reg      <= 3'd0;
            seq_mode_reg     <= M_IDLE;
            pending_op_reg   <= REQ_WRITE;
            pending_byte_reg <= 8'h00;
            pending_last_reg <= 1'b0;
            chunk_count_reg  <= '0;
            next_address_reg <= '0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (move)
            begin
                out_cnt_reg      <= n_v;
                seq_mode_reg     <= seq_mode_next;
                pending_op_reg   <= pending_op_next;
                pending_byte_reg <= pending_byte_next;
                pending_last_reg <= pending_last_next;
                chunk_count_reg  <= chunk_count_next;
                next_address_reg <= next_address_next;
            end
            else if (pop)
            begin
                out_cnt_reg <= out_cnt_reg - 3'd1;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_type_reg <= s_tuser;
            in_addr_reg <= s_tdata[AW-1:0];
            in_data_reg <= s_tdata[23:16];
            in_last_reg <= s_tlast;
        end
        if (move)
        begin
            for (int i = 0; i < MAX_RESULTS; i++)
            begin
                out_buf_reg[i] <= res[i];
            end
        end
        else if (pop)
        begin
            // advance the queue toward the output slot
            for (int i = 0; i < MAX_RESULTS - 1; i++)
            begin
                out_buf_reg[i] <= out_buf_reg[i + 1];
            end
        end
    end

endmodule

`default_nettype wire
